### hdl/tra_pkg.sv
package tra_pkg;

    // Field widths
    localparam int IDX_W    = 12;
    localparam int SAMPLE_W = 32;
    localparam int SHOT_W   = 20;
    localparam int STORE_W  = 48;
    localparam int SUM_W    = STORE_W + 1;
    localparam int NUM_W    = SUM_W + 1;
    localparam int DEN_W    = SHOT_W + 1;

    // Default record length
    localparam int RECORD_DEPTH = 4096;

    // Saturation bounds of a store entry
    localparam logic [STORE_W-1:0] MAX48 = {1'b0, {(STORE_W-1){1'b1}}};
    localparam logic [STORE_W-1:0] MIN48 = {1'b1, {(STORE_W-1){1'b0}}};
    localparam logic [SHOT_W-1:0]  SHOT_MAX = {SHOT_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_LIMIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_ENABLED = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } t_state;

    // Clamp a 49-bit sum into the signed 48-bit range
    function automatic logic [STORE_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
        logic [STORE_W-1:0] v;
        if (s[SUM_W-1] != s[SUM_W-2]) begin
            v = s[SUM_W-1] ? MIN48 : MAX48;
        end else begin
            v = s[STORE_W-1:0];
        end
        return v;
    endfunction

    // Finish the rolling average from magnitude and quotient, apply sign and clamp
    function automatic logic [STORE_W-1:0] roll_result(
        input logic [SUM_W-1:0] mag,
        input logic             neg,
        input logic             le_half,
        input logic [SUM_W-1:0] quo
    );
        logic [SUM_W-1:0]   r;
        logic [SUM_W-1:0]   nr;
        logic [STORE_W-1:0] v;
        r  = le_half ? mag : (mag - quo);
        nr = ~r + {{(SUM_W-1){1'b0}}, 1'b1};
        if (!neg) begin
            v = (r > {1'b0, MAX48}) ? MAX48 : r[STORE_W-1:0];
        end else begin
            v = (r > {1'b0, MIN48}) ? MIN48 : nr[STORE_W-1:0];
        end
        return v;
    endfunction

endpackage

### hdl/trace_rolling_average_accumulator.sv
// Trace rolling average accumulator.
// Input channel (i_valid / o_stall) moves one sample transfer: index, signal
// and reference sample, shot count of the incoming trace and a last mark.
// Output channel (o_valid / i_stall) moves one result per input: the updated
// store entries, the shot count after the item and the last mark echoed.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// average_limit (index 0) and reference_enabled (index 1); the user must
// write them only while idle, and the block does not enforce it.
// Items are taken one at a time. While the summing rule applies, or the index
// lies outside the record, an item passes accept, store read, then write back,
// where its result loads the output register. When the rolling average applies,
// a 50-step bit-serial divider runs between the store read and the write back.
// After reset the block runs a clearing pass over all RECORD_DEPTH entries of
// both stores, with o_stall high; configuration writes are taken during it.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted, and its finish waits until the register is free.
module trace_rolling_average_accumulator #(
    parameter int RECORD_DEPTH = tra_pkg::RECORD_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [tra_pkg::IDX_W-1:0]            i_sample_index,
    input  logic signed [tra_pkg::SAMPLE_W-1:0]  i_signal_sample,
    input  logic signed [tra_pkg::SAMPLE_W-1:0]  i_reference_sample,
    input  logic [tra_pkg::SHOT_W-1:0]           i_trace_shots,
    input  logic                                 i_last_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [tra_pkg::STORE_W-1:0]   o_signal_value,
    output logic signed [tra_pkg::STORE_W-1:0]   o_reference_value,
    output logic [tra_pkg::SHOT_W-1:0]           o_stored_shots,
    output logic                                 o_trace_done,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tra_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tra_pkg::SHOT_W-1:0]           i_cfg_data
);

    localparam int AW  = $clog2(RECORD_DEPTH);
    localparam int IW  = tra_pkg::IDX_W;
    localparam int SW  = tra_pkg::STORE_W;
    localparam int UW  = tra_pkg::SUM_W;
    localparam int NW  = tra_pkg::NUM_W;
    localparam int DW  = tra_pkg::DEN_W;
    localparam int HW  = tra_pkg::SHOT_W;
    localparam int XW  = tra_pkg::SAMPLE_W;

    tra_pkg::t_state r_state;
    tra_pkg::t_state n_state;

    // Configuration and shot count
    logic [HW-1:0] r_lim;
    logic          r_ref_en;
    logic [HW-1:0] r_shot;

    // Captured item
    logic [AW-1:0] r_idx;
    logic          r_in_range;
    logic [XW-1:0] r_sig;
    logic [XW-1:0] r_ref;
    logic [HW-1:0] r_shots;
    logic          r_last;

    // Rolling average operands and results
    logic [UW-1:0] r_mag_s;
    logic [UW-1:0] r_mag_r;
    logic          r_neg_s;
    logic          r_neg_r;
    logic          r_leh_s;
    logic          r_leh_r;
    logic [HW-1:0] r_shot_new;
    logic [SW-1:0] r_sv;
    logic [SW-1:0] r_rv;

    // Clearing pass
    logic [AW-1:0] r_clr_addr;

    // Output register
    logic          r_out_valid;
    logic [SW-1:0] r_out_sv;
    logic [SW-1:0] r_out_rv;
    logic [HW-1:0] r_out_shots;
    logic          r_out_done;

    logic [AW+IW-1:0] idx_wide;
    logic             in_range_c;
    logic [AW-1:0]    raddr;
    logic [SW-1:0]    rdata_s;
    logic [SW-1:0]    rdata_r;

    logic [DW-1:0]    den;
    logic [HW-1:0]    half;
    logic [DW-1:0]    shot_sum;
    logic             plain;
    logic             fast;
    logic [HW-1:0]    shot_new;
    logic [UW-1:0]    sum_s;
    logic [UW-1:0]    sum_r;
    logic [UW-1:0]    mag_s;
    logic [UW-1:0]    mag_r;
    logic             leh_s;
    logic             leh_r;
    logic [NW-1:0]    num_s;
    logic [NW-1:0]    num_r;
    logic [SW-1:0]    res_s;
    logic [SW-1:0]    res_r;

    logic [NW-1:0]    quo_s;
    logic [NW-1:0]    quo_r;
    logic             busy_s;
    logic             busy_r;
    logic             done_s;
    logic             done_r;

    logic             out_free;
    logic             fin;
    logic             div_start;
    logic             clr;
    logic             we_s;
    logic             we_r;
    logic [AW-1:0]    waddr;
    logic [SW-1:0]    wdata_s;
    logic [SW-1:0]    wdata_r;
    logic [HW-1:0]    fin_shot;

    // Index decode
    assign idx_wide   = {{AW{1'b0}}, i_sample_index};
    assign in_range_c = idx_wide < (AW+IW)'(RECORD_DEPTH);
    assign raddr      = (r_state == tra_pkg::ST_IDLE) ? idx_wide[AW-1:0] : r_idx;

    // Rule select and shot count update
    always_comb begin
        den      = {1'b0, r_lim} + {{HW{1'b0}}, 1'b1};
        half     = den[DW-1:1];
        shot_sum = {1'b0, r_shot} + {1'b0, r_shots};
        plain    = shot_sum <= {1'b0, r_lim};
        fast     = plain || !r_in_range;
        if (!r_last) begin
            shot_new = r_shot;
        end else if (plain) begin
            shot_new = shot_sum[HW] ? tra_pkg::SHOT_MAX : shot_sum[HW-1:0];
        end else begin
            shot_new = r_lim;
        end
    end

    // Sums and divider operands
    always_comb begin
        sum_s = {rdata_s[SW-1], rdata_s} + {{(UW-XW){r_sig[XW-1]}}, r_sig};
        sum_r = {rdata_r[SW-1], rdata_r} + {{(UW-XW){r_ref[XW-1]}}, r_ref};
        mag_s = sum_s[UW-1] ? (~sum_s + {{(UW-1){1'b0}}, 1'b1}) : sum_s;
        mag_r = sum_r[UW-1] ? (~sum_r + {{(UW-1){1'b0}}, 1'b1}) : sum_r;
        leh_s = mag_s <= {{(UW-HW){1'b0}}, half};
        leh_r = mag_r <= {{(UW-HW){1'b0}}, half};
        num_s = leh_s ? '0 : ({1'b0, mag_s} + NW'(r_lim) - NW'(half));
        num_r = leh_r ? '0 : ({1'b0, mag_r} + NW'(r_lim) - NW'(half));
    end

    // Result values of the current finish
    always_comb begin
        if (r_state == tra_pkg::ST_READ) begin
            res_s = r_in_range ? tra_pkg::sat_sum(sum_s) : '0;
            res_r = (r_in_range && r_ref_en) ? tra_pkg::sat_sum(sum_r) : '0;
        end else begin
            res_s = tra_pkg::roll_result(r_mag_s, r_neg_s, r_leh_s, quo_s[UW-1:0]);
            res_r = r_ref_en ?
                    tra_pkg::roll_result(r_mag_r, r_neg_r, r_leh_r, quo_r[UW-1:0]) : '0;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tra_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(RECORD_DEPTH - 1)) n_state = tra_pkg::ST_IDLE;
            end
            tra_pkg::ST_IDLE: begin
                if (i_valid) n_state = tra_pkg::ST_READ;
            end
            tra_pkg::ST_READ: begin
                if (!fast) n_state = tra_pkg::ST_DIV;
                else n_state = out_free ? tra_pkg::ST_IDLE : tra_pkg::ST_OUT;
            end
            tra_pkg::ST_DIV: begin
                if (done_s) n_state = out_free ? tra_pkg::ST_IDLE : tra_pkg::ST_OUT;
            end
            tra_pkg::ST_OUT: begin
                if (out_free) n_state = tra_pkg::ST_IDLE;
            end
            default: n_state = tra_pkg::ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        clr       = 1'b0;
        fin       = 1'b0;
        div_start = 1'b0;
        o_stall   = 1'b1;
        unique case (r_state)
            tra_pkg::ST_CLEAR: clr = 1'b1;
            tra_pkg::ST_IDLE:  o_stall = 1'b0;
            tra_pkg::ST_READ: begin
                div_start = !fast;
                fin       = fast && out_free;
            end
            tra_pkg::ST_DIV:   fin = done_s && out_free;
            tra_pkg::ST_OUT:   fin = out_free;
            default: clr = 1'b0;
        endcase
    end

    // Store write port
    always_comb begin
        we_s     = clr || (fin && r_in_range);
        we_r     = clr || (fin && r_in_range && r_ref_en);
        waddr    = clr ? r_clr_addr : r_idx;
        wdata_s  = clr ? '0 : ((r_state == tra_pkg::ST_OUT) ? r_sv : res_s);
        wdata_r  = clr ? '0 : ((r_state == tra_pkg::ST_OUT) ? r_rv : res_r);
        fin_shot = (r_state == tra_pkg::ST_READ) ? shot_new : r_shot_new;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tra_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_lim       <= {{(HW-1){1'b0}}, 1'b1};
            r_ref_en    <= 1'b0;
            r_shot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tra_pkg::CFG_AVERAGE_LIMIT:     r_lim    <= i_cfg_data;
                    tra_pkg::CFG_REFERENCE_ENABLED: r_ref_en <= i_cfg_data[0];
                    default:                        r_ref_en <= r_ref_en;
                endcase
            end
            if (fin) r_shot <= fin_shot;
            if (fin) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // capture the item on transfer
        if (r_state == tra_pkg::ST_IDLE && i_valid) begin
            r_idx      <= idx_wide[AW-1:0];
            r_in_range <= in_range_c;
            r_sig      <= i_signal_sample;
            r_ref      <= i_reference_sample;
            r_shots    <= i_trace_shots;
            r_last     <= i_last_sample;
        end
        // hold divider operands
        if (r_state == tra_pkg::ST_READ) begin
            r_mag_s    <= mag_s;
            r_mag_r    <= mag_r;
            r_neg_s    <= sum_s[UW-1];
            r_neg_r    <= sum_r[UW-1];
            r_leh_s    <= leh_s;
            r_leh_r    <= leh_r;
            r_shot_new <= shot_new;
        end
        // hold results that wait for the output register
        if ((r_state == tra_pkg::ST_READ && fast) || (r_state == tra_pkg::ST_DIV && done_s)) begin
            r_sv <= res_s;
            r_rv <= res_r;
        end
        if (fin) begin
            r_out_sv    <= wdata_s;
            r_out_rv    <= (r_in_range && r_ref_en) ? wdata_r : '0;
            r_out_shots <= fin_shot;
            r_out_done  <= r_last;
        end
    end

    tra_ram #(.WIDTH(SW), .DEPTH(RECORD_DEPTH)) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (we_s),
        .i_waddr (waddr),
        .i_wdata (wdata_s),
        .i_raddr (raddr),
        .o_rdata (rdata_s)
    );

    tra_ram #(.WIDTH(SW), .DEPTH(RECORD_DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_waddr (waddr),
        .i_wdata (wdata_r),
        .i_raddr (raddr),
        .o_rdata (rdata_r)
    );

    tra_div #(.NW(NW), .DW(DW)) u_sig_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_s),
        .i_den   (den),
        .o_quo   (quo_s),
        .o_busy  (busy_s),
        .o_done  (done_s)
    );

    tra_div #(.NW(NW), .DW(DW)) u_ref_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_r),
        .i_den   (den),
        .o_quo   (quo_r),
        .o_busy  (busy_r),
        .o_done  (done_r)
    );

    assign o_valid           = r_out_valid;
    assign o_signal_value    = r_out_sv;
    assign o_reference_value = r_out_rv;
    assign o_stored_shots    = r_out_shots;
    assign o_trace_done      = r_out_done;
    assign o_cfg_ready       = 1'b1;

    // A finished item always reaches the output register
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> o_valid) else $error("finished item not presented");

    // Both dividers run in lockstep
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_s == done_r) && (busy_s == busy_r)) else $error("dividers out of step");

    // Divider works only while the sequencer waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_s |-> (r_state == tra_pkg::ST_DIV)) else $error("divider busy outside wait");

    // Shot count moves only at the finish of a last sample
    a_shot_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_shot)) |-> $past(fin && r_last))
        else $error("shot count changed outside trace end");

endmodule

### hdl/tra_ram.sv
module tra_ram #(
    parameter int WIDTH = tra_pkg::STORE_W,
    parameter int DEPTH = tra_pkg::RECORD_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tra_div.sv
module tra_div #(
    parameter int NW = tra_pkg::NUM_W,
    parameter int DW = tra_pkg::DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_busy,
    output logic          o_done
);

    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_sub;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // Control: run NW steps after start, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

### bench/tb_trace_rolling_average_accumulator.sv
`timescale 1ns / 100ps

module tb_trace_rolling_average_accumulator;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 80;
    localparam int PHASE_ITEMS = 190;
    localparam int IW          = tra_pkg::IDX_W;
    localparam int XW          = tra_pkg::SAMPLE_W;
    localparam int HW          = tra_pkg::SHOT_W;
    localparam int SW          = tra_pkg::STORE_W;
    localparam int CW          = tra_pkg::CFG_IDX_W;
    localparam int DEPTH       = tra_pkg::RECORD_DEPTH;

    typedef struct {
        logic signed [SW-1:0] signal_value;
        logic signed [SW-1:0] reference_value;
        logic [HW-1:0]        stored_shots;
        logic                 trace_done;
    } t_entry;

    typedef struct {
        logic [IW-1:0]         idx;
        logic signed [XW-1:0]  sig;
        logic signed [XW-1:0]  refs;
        logic [HW-1:0]         shots;
        logic                  last;
        logic                  known;
        t_entry                want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [IW-1:0]          i_sample_index = '0;
    logic signed [XW-1:0]   i_signal_sample = '0;
    logic signed [XW-1:0]   i_reference_sample = '0;
    logic [HW-1:0]          i_trace_shots = '0;
    logic                   i_last_sample = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [SW-1:0]   o_signal_value;
    logic signed [SW-1:0]   o_reference_value;
    logic [HW-1:0]          o_stored_shots;
    logic                   o_trace_done;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CW-1:0]          i_cfg_index = '0;
    logic [HW-1:0]          i_cfg_data = '0;

    trace_rolling_average_accumulator DUT (.*);

    // Shadow state of the accumulator
    logic signed [SW-1:0] sig_mem [DEPTH];
    logic signed [SW-1:0] ref_mem [DEPTH];
    logic [HW-1:0]        shot_total;
    logic [HW-1:0]        avg_limit;
    logic                 ref_on;

    t_entry pending_q [$];
    int     errors = 0;
    int     cycles = 0;
    bit     quiet = 0;

    t_row directed [5] = '{
        '{12'd0, 32'sh7FFFFFFF, 32'sh80000000, 20'd1, 1'b0, 1'b1,
          '{48'sd2147483647, 48'sd0, 20'd0, 1'b0}},
        '{12'd4095, 32'sh80000000, 32'sh7FFFFFFF, 20'd1, 1'b1, 1'b1,
          '{-48'sd2147483648, 48'sd0, 20'd1, 1'b1}},
        '{12'd0, 32'sd1, 32'sd5, 20'd1, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}},
        '{12'd4095, 32'sd0, 32'sd0, 20'hFFFFF, 1'b1, 1'b0, '{'0, '0, '0, 1'b0}},
        '{12'd1, -32'sd3, 32'sd3, 20'd1, 1'b1, 1'b0, '{'0, '0, '0, 1'b0}}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Round lim*s/(lim+1), ties away from zero, clamped to 48 bits
    function automatic longint roll_average(longint s, longint unsigned lim);
        longint unsigned d, h, m, r;
        d = lim + 1;
        h = d / 2;
        m = (s < 0) ? longint'(-s) : longint'(s);
        r = (m <= h) ? m : m - (m - h + d - 1) / d;
        if (s >= 0) begin
            if (r > 64'h7FFFFFFFFFFF) r = 64'h7FFFFFFFFFFF;
            return longint'(r);
        end
        if (r > 64'h800000000000) r = 64'h800000000000;
        return -longint'(r);
    endfunction

    function automatic longint merge_entry(longint stored, longint smp, bit plain,
                                           longint unsigned lim);
        longint s;
        s = stored + smp;
        if (!plain) return roll_average(s, lim);
        if (s > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
        if (s < -64'sh800000000000) return -64'sh800000000000;
        return s;
    endfunction

    // Fold one accepted sample into the shadow stores
    function automatic t_entry accumulate_sample(t_row it);
        t_entry e;
        longint unsigned total;
        longint unsigned lim;
        bit plain;
        lim = longint'(avg_limit);
        total = longint'(shot_total) + longint'(it.shots);
        plain = total <= lim;
        e.signal_value = SW'(merge_entry(longint'(sig_mem[it.idx]), longint'(it.sig),
                                         plain, lim));
        sig_mem[it.idx] = e.signal_value;
        e.reference_value = '0;
        if (ref_on) begin
            e.reference_value = SW'(merge_entry(longint'(ref_mem[it.idx]),
                                                longint'(it.refs), plain, lim));
            ref_mem[it.idx] = e.reference_value;
        end
        if (it.last) shot_total = !plain ? avg_limit :
                                  (total > 20'hFFFFF) ? 20'hFFFFF : total[HW-1:0];
        e.stored_shots = shot_total;
        e.trace_done = it.last;
        return e;
    endfunction

    // Present one sample and hold it until the transfer
    task automatic send_sample(t_row it);
        t_entry e;
        if (!quiet && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_index <= it.idx;
        i_signal_sample <= it.sig;
        i_reference_sample <= it.refs;
        i_trace_shots <= it.shots;
        i_last_sample <= it.last;
        do @(posedge i_clk); while (o_stall);
        e = accumulate_sample(it);
        if (it.known) pending_q.push_back(it.want);
        else pending_q.push_back(e);
    endtask

    // Drain, then write one register
    task automatic write_reg(logic [CW-1:0] idx, logic [HW-1:0] data);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == tra_pkg::CFG_AVERAGE_LIMIT) avg_limit = data;
        else ref_on = data[0];
    endtask

    function automatic logic [XW-1:0] rand_sample();
        unique case ($urandom_range(3))
            0: return $urandom_range(200) - 100;
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [HW-1:0] rand_shots();
        unique case ($urandom_range(3))
            0: return 20'hFFFFF;
            1: return HW'($urandom_range(20'hFFFFF, 1));
            default: return HW'($urandom_range(8, 1));
        endcase
    endfunction

    // Mostly whole traces, some stray samples
    task automatic random_items(int count);
        t_row it;
        int n, base;
        while (count > 0) begin
            it.known = 1'b0;
            if ($urandom_range(6) == 0) begin
                it.idx = IW'($urandom);
                it.sig = rand_sample();
                it.refs = rand_sample();
                it.shots = HW'($urandom);
                it.last = 1'($urandom_range(1));
                send_sample(it);
                count--;
            end else begin
                n = $urandom_range(16, 1);
                base = ($urandom_range(7) == 0) ? $urandom_range(4095 - 16) : 0;
                it.shots = rand_shots();
                for (int k = 0; k < n; k++) begin
                    it.idx = IW'(base + k);
                    it.sig = rand_sample();
                    it.refs = rand_sample();
                    it.last = (k == n - 1);
                    send_sample(it);
                end
                count -= n;
            end
        end
    endtask

    // Receiver stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left == 0) begin
            stall_left <= $urandom_range(16, 1);
            i_stall <= 1'($urandom_range(1));
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_entry w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result signal=%0d", $time, o_signal_value);
                errors++;
            end else begin
                w = pending_q.pop_front();
                if (o_signal_value !== w.signal_value ||
                    o_reference_value !== w.reference_value ||
                    o_stored_shots !== w.stored_shots || o_trace_done !== w.trace_done) begin
                    $display("%0t: expected sig=%0d ref=%0d shots=%0d done=%0b", $time,
                             w.signal_value, w.reference_value, w.stored_shots,
                             w.trace_done);
                    $display("%0t: actual   sig=%0d ref=%0d shots=%0d done=%0b", $time,
                             o_signal_value, o_reference_value, o_stored_shots,
                             o_trace_done);
                    errors++;
                end
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [HW-1:0] limits [6];
        for (int k = 0; k < DEPTH; k++) begin
            sig_mem[k] = '0;
            ref_mem[k] = '0;
        end
        shot_total = '0;
        avg_limit = 20'd1;
        ref_on = 1'b0;
        limits = '{20'd1, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0};
        limits[4] = HW'($urandom_range(64, 2));
        limits[5] = HW'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at reset configuration
        foreach (directed[r]) send_sample(directed[r]);

        // Random phases under several settings
        for (int p = 0; p < 6; p++) begin
            write_reg(tra_pkg::CFG_AVERAGE_LIMIT, limits[p]);
            write_reg(tra_pkg::CFG_REFERENCE_ENABLED, (p == 2) ? 20'd0 : 20'd1);
            if (p == 5) quiet = 1;
            random_items(PHASE_ITEMS);
        end
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
